FILE: design/tbpf_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and tables for the tile background pixel fetch block.
package tbpf_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_PIXEL = 2'd2
    } op_t;

    typedef enum logic {
        CFG_MIRROR_MODE     = 1'b0,
        CFG_BG_PATTERN_HALF = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_READ_DONE,
        ST_PIX_PAT_LO,
        ST_PIX_PAT_HI,
        ST_PIX_PAL,
        ST_PIX_COLOR
    } state_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
    } tbpf_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } tbpf_rsp_t;

    localparam logic [5:0] PAL_PAGE     = 6'h3F;
    localparam logic [3:0] ATTR_ROW_SEL = 4'hF;

    localparam logic [23:0] COLOR_RGB [64] = '{
        24'h7F7F7F, 24'h2000B0, 24'h2800B8, 24'h6010A0,
        24'h982078, 24'hB01030, 24'hA03000, 24'h784000,
        24'h485800, 24'h386800, 24'h386C00, 24'h306040,
        24'h305080, 24'h000000, 24'h000000, 24'h000000,
        24'hBCBCBC, 24'h4060F8, 24'h4040FF, 24'h9040F0,
        24'hD840C0, 24'hD84060, 24'hE05000, 24'hC07000,
        24'h888800, 24'h50A000, 24'h48A810, 24'h48A068,
        24'h4090C0, 24'h000000, 24'h000000, 24'h000000,
        24'hFFFFFF, 24'h60A0FF, 24'h5080FF, 24'hA070FF,
        24'hF060FF, 24'hFF60B0, 24'hFF7830, 24'hFFA000,
        24'hE8D020, 24'h98E800, 24'h70F040, 24'h70E090,
        24'h60D0E0, 24'h606060, 24'h000000, 24'h000000,
        24'hFFFFFF, 24'h90D0FF, 24'hA0B8FF, 24'hC0B0FF,
        24'hE0B0FF, 24'hFFB8E8, 24'hFFC8B8, 24'hFFD8A0,
        24'hFFF090, 24'hC8F080, 24'hA0F0A0, 24'hA0FFC8,
        24'hA0FFF0, 24'hA0A0A0, 24'h000000, 24'h000000
    };

    // Fold a 5-bit palette address onto the 28 stored entries.
    function automatic logic [4:0] pal_slot(input logic [4:0] a);
        logic [4:0] s;
        if (!a[4])
        begin
            s = a;
        end
        else if (a[1:0] == 2'b00)
        begin
            s = {1'b0, a[3:0]};
        end
        else
        begin
            s = 5'd15 + {2'b00, a[3:2], 1'b0} + {3'b000, a[3:2]} + {3'b000, a[1:0]};
        end
        return s;
    endfunction

endpackage

FILE: design/tile_background_pixel_fetch.sv
`timescale 1ns / 1ps
// Top level: video memory with byte access and background pixel color lookup.
// After accept, a write is answered from ACCESS, a read from READ_DONE, a pixel from PIX_COLOR.
// One item at a time; the next item is taken the cycle after the result is loaded.
// A pixel runs through the chain nametable, two pattern planes, palette.
// Reset clears control and config; the stores hold unknown data until written.
module tile_background_pixel_fetch
    import tbpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  tbpf_req_t  req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output tbpf_rsp_t  rsp,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic       cfg_data
);

    state_t     state_reg, state_next;
    tbpf_req_t  item_reg;
    logic       mirror_mode_reg;
    logic       bg_half_reg;

    logic [7:0] pattern_mem [8192];
    logic [7:0] nametable_mem [2048];
    logic [7:0] palette_mem [28];

    logic [7:0] pat_rd_reg, nt_rd_reg, pal_rd_reg;
    logic [7:0] tile_reg;
    logic       lo_bit_reg;
    logic [1:0] section_reg;

    logic        pat_re, pat_we, nt_re, nt_we, pal_re, pal_we;
    logic [12:0] pattern_addr;
    logic [10:0] nt_addr;
    logic [4:0]  pal_addr;

    logic        rsp_valid_reg;
    tbpf_rsp_t   rsp_reg, rsp_next;
    logic        load_rsp;
    logic        rsp_free;

    logic [13:0] vaddr;
    logic        is_pal, is_pat;
    logic [10:0] nt_index;
    logic [2:0]  bit_sel;
    logic [3:0]  pix_idx;
    logic [23:0] rgb;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    assign vaddr    = item_reg.address[13:0];
    assign is_pal   = (vaddr[13:8] == PAL_PAGE);
    assign is_pat   = !vaddr[13];
    assign nt_index = {(mirror_mode_reg ? vaddr[11] : vaddr[10]), vaddr[9:0]};
    assign bit_sel  = ~item_reg.pixel_x[2:0];

    always_comb
    begin
        pix_idx = {section_reg, pat_rd_reg[bit_sel], lo_bit_reg};
        if (pix_idx[1:0] == 2'b00)
        begin
            pix_idx = 4'd0;
        end
    end

    assign rgb = COLOR_RGB[pal_rd_reg[5:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_mode_reg <= 1'b0;
            bg_half_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MIRROR_MODE:     mirror_mode_reg <= cfg_data;
                CFG_BG_PATTERN_HALF: bg_half_reg     <= cfg_data;
                default:             mirror_mode_reg <= mirror_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg <= req;
        end
        if (load_rsp)
        begin
            rsp_reg <= rsp_next;
        end
        if (state_reg == ST_PIX_PAT_LO)
        begin
            tile_reg <= nt_rd_reg;
        end
        if (state_reg == ST_PIX_PAT_HI)
        begin
            lo_bit_reg  <= pat_rd_reg[bit_sel];
            section_reg <= nt_rd_reg[{item_reg.pixel_y[4], item_reg.pixel_x[4], 1'b0} +: 2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pattern_mem[pattern_addr] <= item_reg.write_data;
        end
        if (pat_re)
        begin
            pat_rd_reg <= pattern_mem[pattern_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nt_we)
        begin
            nametable_mem[nt_addr] <= item_reg.write_data;
        end
        if (nt_re)
        begin
            nt_rd_reg <= nametable_mem[nt_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            palette_mem[pal_addr] <= item_reg.write_data;
        end
        if (pal_re)
        begin
            pal_rd_reg <= palette_mem[pal_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                case (item_reg.op)
                    OP_READ:  state_next = ST_READ_DONE;
                    OP_PIXEL: state_next = ST_PIX_PAT_LO;
                    default:
                    begin
                        if (rsp_free)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_READ_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PIX_PAT_LO: state_next = ST_PIX_PAT_HI;
            ST_PIX_PAT_HI: state_next = ST_PIX_PAL;
            ST_PIX_PAL:    state_next = ST_PIX_COLOR;
            ST_PIX_COLOR:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pat_re       = 1'b0;
        pat_we       = 1'b0;
        nt_re        = 1'b0;
        nt_we        = 1'b0;
        pal_re       = 1'b0;
        pal_we       = 1'b0;
        pattern_addr = vaddr[12:0];
        nt_addr      = nt_index;
        pal_addr     = pal_slot(vaddr[4:0]);
        load_rsp     = 1'b0;
        rsp_next     = '0;
        case (state_reg)
            ST_ACCESS:
            begin
                case (item_reg.op)
                    OP_WRITE:
                    begin
                        pal_we   = is_pal;
                        pat_we   = is_pat;
                        nt_we    = !is_pal && !is_pat;
                        load_rsp = rsp_free;
                    end
                    OP_READ:
                    begin
                        pal_re = is_pal;
                        pat_re = is_pat;
                        nt_re  = !is_pal && !is_pat;
                    end
                    OP_PIXEL:
                    begin
                        nt_re   = 1'b1;
                        nt_addr = {1'b0, item_reg.pixel_y[7:3], item_reg.pixel_x[7:3]};
                    end
                    default:
                    begin
                        load_rsp = rsp_free;
                    end
                endcase
            end
            ST_READ_DONE:
            begin
                load_rsp = rsp_free;
                if (is_pal)
                begin
                    rsp_next.read_data = pal_rd_reg;
                end
                else if (is_pat)
                begin
                    rsp_next.read_data = pat_rd_reg;
                end
                else
                begin
                    rsp_next.read_data = nt_rd_reg;
                end
            end
            ST_PIX_PAT_LO:
            begin
                pat_re       = 1'b1;
                pattern_addr = {bg_half_reg, nt_rd_reg, 1'b0, item_reg.pixel_y[2:0]};
                nt_re        = 1'b1;
                nt_addr      = {1'b0, ATTR_ROW_SEL, item_reg.pixel_y[7:5], item_reg.pixel_x[7:5]};
            end
            ST_PIX_PAT_HI:
            begin
                pat_re       = 1'b1;
                pattern_addr = {bg_half_reg, tile_reg, 1'b1, item_reg.pixel_y[2:0]};
            end
            ST_PIX_PAL:
            begin
                pal_re   = 1'b1;
                pal_addr = {1'b0, pix_idx};
            end
            ST_PIX_COLOR:
            begin
                load_rsp       = rsp_free;
                rsp_next.red   = rgb[23:16];
                rsp_next.green = rgb[15:8];
                rsp_next.blue  = rgb[7:0];
            end
            default:
            begin
                load_rsp = 1'b0;
            end
        endcase
    end

endmodule

FILE: tb/sv/tb_tile_background_pixel_fetch.sv
`timescale 1ns / 1ps
// Testbench for the tile background pixel fetch block: scripted and random beats against a predictor.
module tb_tile_background_pixel_fetch;
    import tbpf_pkg::*;

    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam int         STALL_LIMIT     = 3000;
    localparam int         LONG_HOLD       = 400;
    localparam int         ITEMS_PER_PHASE = 165;

    localparam logic [23:0] SCREEN_RGB [64] = '{
        24'h7F7F7F, 24'h2000B0, 24'h2800B8, 24'h6010A0, 24'h982078, 24'hB01030,
        24'hA03000, 24'h784000, 24'h485800, 24'h386800, 24'h386C00, 24'h306040,
        24'h305080, 24'h000000, 24'h000000, 24'h000000, 24'hBCBCBC, 24'h4060F8,
        24'h4040FF, 24'h9040F0, 24'hD840C0, 24'hD84060, 24'hE05000, 24'hC07000,
        24'h888800, 24'h50A000, 24'h48A810, 24'h48A068, 24'h4090C0, 24'h000000,
        24'h000000, 24'h000000, 24'hFFFFFF, 24'h60A0FF, 24'h5080FF, 24'hA070FF,
        24'hF060FF, 24'hFF60B0, 24'hFF7830, 24'hFFA000, 24'hE8D020, 24'h98E800,
        24'h70F040, 24'h70E090, 24'h60D0E0, 24'h606060, 24'h000000, 24'h000000,
        24'hFFFFFF, 24'h90D0FF, 24'hA0B8FF, 24'hC0B0FF, 24'hE0B0FF, 24'hFFB8E8,
        24'hFFC8B8, 24'hFFD8A0, 24'hFFF090, 24'hC8F080, 24'hA0F0A0, 24'hA0FFC8,
        24'hA0FFF0, 24'hA0A0A0, 24'h000000, 24'h000000
    };

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  px;
        logic [7:0]  py;
        logic        typed;
        logic [7:0]  want_byte;
        logic [23:0] want_rgb;
    } script_row_t;

    localparam script_row_t SCRIPT [23] = '{
        '{OP_WRITE,  16'h0000, 8'hFF, 8'h00, 8'h00, 1'b1, 8'h00, 24'h0},
        '{OP_READ,   16'h0000, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF, 24'h0},
        '{OP_WRITE,  16'h1FFF, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 24'h0},
        '{OP_READ,   16'h5FFF, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 24'h0},
        '{OP_WRITE,  16'hFFFF, 8'hA5, 8'h00, 8'h00, 1'b1, 8'h00, 24'h0},
        '{OP_READ,   16'h3FFF, 8'h00, 8'h00, 8'h00, 1'b1, 8'hA5, 24'h0},
        '{OP_WRITE,  16'h3F10, 8'h21, 8'h00, 8'h00, 1'b1, 8'h00, 24'h0},
        '{OP_READ,   16'h3F00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h21, 24'h0},
        '{OP_WRITE,  16'h3F1C, 8'hFE, 8'h00, 8'h00, 1'b1, 8'h00, 24'h0},
        '{OP_READ,   16'h3F0C, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFE, 24'h0},
        '{OP_WRITE,  16'h2000, 8'h01, 8'h00, 8'h00, 1'b1, 8'h00, 24'h0},
        '{OP_READ,   16'h2800, 8'h00, 8'h00, 8'h00, 1'b1, 8'h01, 24'h0},
        '{OP_READ,   16'h3000, 8'h00, 8'h00, 8'h00, 1'b1, 8'h01, 24'h0},
        '{OP_WRITE,  16'h2400, 8'h7E, 8'h00, 8'h00, 1'b1, 8'h00, 24'h0},
        '{OP_READ,   16'h2C00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h7E, 24'h0},
        '{OP_READ,   16'hEC00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h7E, 24'h0},
        '{OP_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00, 24'h0},
        '{OP_PIXEL,  16'h0000, 8'h00, 8'd0,   8'd0,   1'b0, 8'h00, 24'h0},
        '{OP_PIXEL,  16'h0000, 8'h00, 8'd255, 8'd239, 1'b0, 8'h00, 24'h0},
        '{OP_PIXEL,  16'h0000, 8'h00, 8'd255, 8'd255, 1'b0, 8'h00, 24'h0},
        '{OP_PIXEL,  16'h0000, 8'h00, 8'd7,   8'd7,   1'b0, 8'h00, 24'h0},
        '{OP_WRITE,  16'h3F00, 8'hFF, 8'h00, 8'h00, 1'b0, 8'h00, 24'h0},
        '{OP_PIXEL,  16'h0000, 8'h00, 8'd0,   8'd0,   1'b0, 8'h00, 24'h0}
    };

    typedef enum logic [1:0] {
        IN_PATTERN,
        IN_NAMETABLE,
        IN_PALETTE
    } vram_bank_t;

    typedef struct packed {
        vram_bank_t  bank;
        logic [12:0] slot;
    } vram_loc_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    tbpf_req_t  req = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    tbpf_rsp_t  rsp;
    logic       cfg_write = 1'b0;
    logic       cfg_index = 1'b0;
    logic       cfg_data = 1'b0;

    logic [7:0]  pattern_bytes [8192];
    logic [7:0]  nametable_bytes [2048];
    logic [7:0]  palette_bytes [28];
    bit          pattern_set [8192];
    bit          nametable_set [2048];
    bit          palette_set [28];
    logic        mirror_cfg = 1'b0;
    logic        half_cfg = 1'b0;
    logic [15:0] written_addrs [$];

    tbpf_rsp_t   due_rsp_q [$];
    tbpf_rsp_t   owed;
    int          err_count = 0;
    int          stall_cycles = 0;
    int          beats_sent = 0;
    bit          sender_idle_on = 1'b0;
    bit          rsp_idle_on = 1'b0;
    bit          long_hold_pending = 1'b0;

    tile_background_pixel_fetch dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [4:0] palette_fold(logic [4:0] a);
        if (!a[4])
        begin
            return a;
        end
        if (a[1:0] == 2'b00)
        begin
            return {1'b0, a[3:0]};
        end
        return 5'(15 + 3 * a[3:2] + a[1:0]);
    endfunction

    function automatic vram_loc_t decode_vaddr(logic [15:0] a);
        vram_loc_t loc;
        logic      bank_b;
        if (a[13:0] >= 14'h3F00)
        begin
            loc.bank = IN_PALETTE;
            loc.slot = {8'b0, palette_fold(a[4:0])};
        end
        else if (a[13:0] < 14'h2000)
        begin
            loc.bank = IN_PATTERN;
            loc.slot = a[12:0];
        end
        else
        begin
            bank_b = mirror_cfg ? a[11] : a[10];
            loc.bank = IN_NAMETABLE;
            loc.slot = {2'b0, bank_b, a[9:0]};
        end
        return loc;
    endfunction

    function automatic logic [7:0] peek(logic [15:0] a);
        vram_loc_t loc;
        loc = decode_vaddr(a);
        case (loc.bank)
            IN_PATTERN:   return pattern_bytes[loc.slot];
            IN_NAMETABLE: return nametable_bytes[loc.slot[10:0]];
            default:      return palette_bytes[loc.slot[4:0]];
        endcase
    endfunction

    function automatic bit is_set(logic [15:0] a);
        vram_loc_t loc;
        loc = decode_vaddr(a);
        case (loc.bank)
            IN_PATTERN:   return pattern_set[loc.slot];
            IN_NAMETABLE: return nametable_set[loc.slot[10:0]];
            default:      return palette_set[loc.slot[4:0]];
        endcase
    endfunction

    function automatic void poke(logic [15:0] a, logic [7:0] d);
        vram_loc_t loc;
        loc = decode_vaddr(a);
        case (loc.bank)
            IN_PATTERN:
            begin
                pattern_bytes[loc.slot] = d;
                pattern_set[loc.slot] = 1'b1;
            end
            IN_NAMETABLE:
            begin
                nametable_bytes[loc.slot[10:0]] = d;
                nametable_set[loc.slot[10:0]] = 1'b1;
            end
            default:
            begin
                palette_bytes[loc.slot[4:0]] = d;
                palette_set[loc.slot[4:0]] = 1'b1;
            end
        endcase
        written_addrs.push_back({2'b00, a[13:0]});
    endfunction

    function automatic logic [15:0] tile_addr(logic [7:0] x, logic [7:0] y);
        return 16'h2000 | {6'b0, y[7:3], x[7:3]};
    endfunction

    function automatic logic [15:0] attr_addr(logic [7:0] x, logic [7:0] y);
        return 16'h23C0 | {10'b0, y[7:5], x[7:5]};
    endfunction

    function automatic logic [15:0] plane_addr(logic [7:0] tile, logic [7:0] y, logic upper);
        return {3'b000, half_cfg, tile, upper, y[2:0]};
    endfunction

    function automatic logic [3:0] palette_index(logic [7:0] x, logic [7:0] y,
                                                 logic [7:0] lo_b, logic [7:0] hi_b,
                                                 logic [7:0] attr);
        logic [1:0] quad;
        logic [3:0] idx;
        quad = attr[{y[4], x[4], 1'b0} +: 2];
        idx = {quad, hi_b[3'd7 - x[2:0]], lo_b[3'd7 - x[2:0]]};
        if (idx[1:0] == 2'b00)
        begin
            idx = 4'h0;
        end
        return idx;
    endfunction

    // First entry a pixel at (x, y) would touch that holds no data yet.
    function automatic bit pixel_gap(logic [7:0] x, logic [7:0] y, output logic [15:0] gap);
        logic [7:0] tile;
        logic [3:0] idx;
        gap = tile_addr(x, y);
        if (!is_set(gap))
        begin
            return 1'b1;
        end
        gap = attr_addr(x, y);
        if (!is_set(gap))
        begin
            return 1'b1;
        end
        tile = peek(tile_addr(x, y));
        gap = plane_addr(tile, y, 1'b0);
        if (!is_set(gap))
        begin
            return 1'b1;
        end
        gap = plane_addr(tile, y, 1'b1);
        if (!is_set(gap))
        begin
            return 1'b1;
        end
        idx = palette_index(x, y, peek(plane_addr(tile, y, 1'b0)),
                            peek(plane_addr(tile, y, 1'b1)), peek(attr_addr(x, y)));
        gap = 16'h3F00 | {12'b0, idx};
        return !is_set(gap);
    endfunction

    function automatic tbpf_rsp_t vram_access_render(tbpf_req_t r);
        tbpf_rsp_t  res;
        logic [7:0] tile;
        logic [3:0] idx;
        res = '0;
        case (r.op)
            OP_WRITE: poke(r.address, r.write_data);
            OP_READ:  res.read_data = peek(r.address);
            OP_PIXEL:
            begin
                tile = peek(tile_addr(r.pixel_x, r.pixel_y));
                idx = palette_index(r.pixel_x, r.pixel_y,
                                    peek(plane_addr(tile, r.pixel_y, 1'b0)),
                                    peek(plane_addr(tile, r.pixel_y, 1'b1)),
                                    peek(attr_addr(r.pixel_x, r.pixel_y)));
                {res.red, res.green, res.blue} = SCREEN_RGB[palette_bytes[idx][5:0]];
            end
            default: ;
        endcase
        return res;
    endfunction

    // Another video address naming the same stored byte.
    function automatic logic [15:0] vary_addr(logic [15:0] a);
        logic [13:0] v;
        v = a[13:0];
        if (v >= 14'h2000 && v < 14'h3000)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                v = v ^ (mirror_cfg ? 14'h0400 : 14'h0800);
            end
            if (v < 14'h2F00 && $urandom_range(0, 1) == 1)
            begin
                v = v + 14'h1000;
            end
        end
        else if (v >= 14'h3F00)
        begin
            v[7:5] = 3'($urandom());
            if (v[1:0] == 2'b00 && $urandom_range(0, 1) == 1)
            begin
                v[4] = ~v[4];
            end
        end
        return {2'($urandom()), v};
    endfunction

    function automatic tbpf_req_t any_req();
        tbpf_req_t r;
        r.op = 2'($urandom());
        r.address = 16'($urandom());
        r.write_data = 8'($urandom());
        r.pixel_x = 8'($urandom());
        r.pixel_y = 8'($urandom());
        return r;
    endfunction

    task automatic note_failure(string msg);
        err_count++;
        if (err_count <= 100)
        begin
            $display("%t mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic send_beat(tbpf_req_t r, logic typed, tbpf_rsp_t want);
        tbpf_rsp_t calc;
        if (sender_idle_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_ready !== 1'b1);
        calc = vram_access_render(r);
        due_rsp_q.push_back(typed ? want : calc);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic write_byte(logic [15:0] a);
        tbpf_req_t r;
        r = any_req();
        r.op = OP_WRITE;
        r.address = a;
        send_beat(r, 1'b0, '0);
    endtask

    task automatic fill_pixel(logic [7:0] x, logic [7:0] y);
        logic [15:0] gap;
        while (pixel_gap(x, y, gap))
        begin
            write_byte(vary_addr(gap));
        end
    endtask

    task automatic random_beat();
        tbpf_req_t r;
        int        pick;
        r = any_req();
        pick = $urandom_range(0, 19);
        if (pick < 6)
        begin
            r.op = OP_WRITE;
        end
        else if (pick < 12)
        begin
            r.op = OP_READ;
            if (written_addrs.size() != 0 && $urandom_range(0, 1) == 1)
            begin
                r.address = vary_addr(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
            end
            if (!is_set(r.address))
            begin
                write_byte(r.address);
            end
        end
        else if (pick < 19)
        begin
            r.op = OP_PIXEL;
            fill_pixel(r.pixel_x, r.pixel_y);
        end
        else
        begin
            r.op = OP_UNUSED;
        end
        send_beat(r, 1'b0, '0);
    endtask

    task automatic write_config(logic mirror, logic half);
        cfg_write <= 1'b1;
        cfg_index <= CFG_MIRROR_MODE;
        cfg_data <= mirror;
        mirror_cfg = mirror;
        @(negedge clk);
        cfg_index <= CFG_BG_PATTERN_HALF;
        cfg_data <= half;
        half_cfg = half;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase(logic mirror, logic half, bit idling, bit hold_off, bit scripted);
        tbpf_req_t r;
        bit        calm;
        int        start_count;
        int        k;
        while (due_rsp_q.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        write_config(mirror, half);
        sender_idle_on = idling;
        rsp_idle_on = idling;
        if (hold_off)
        begin
            long_hold_pending = 1'b1;
        end
        if (scripted)
        begin
            foreach (SCRIPT[i])
            begin
                if (SCRIPT[i].op == OP_PIXEL)
                begin
                    fill_pixel(SCRIPT[i].px, SCRIPT[i].py);
                end
                r.op = SCRIPT[i].op;
                r.address = SCRIPT[i].addr;
                r.write_data = SCRIPT[i].data;
                r.pixel_x = SCRIPT[i].px;
                r.pixel_y = SCRIPT[i].py;
                send_beat(r, SCRIPT[i].typed, {SCRIPT[i].want_byte, SCRIPT[i].want_rgb});
            end
        end
        start_count = beats_sent;
        k = 0;
        while (beats_sent - start_count < ITEMS_PER_PHASE)
        begin
            if (k % 40 == 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
                sender_idle_on = idling && !calm;
                rsp_idle_on = idling && !calm;
            end
            random_beat();
            k++;
        end
        req_valid <= 1'b0;
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (rsp_idle_on && $urandom_range(0, 4) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && rsp_ready)
        begin
            if (due_rsp_q.size() == 0)
            begin
                note_failure($sformatf("result with nothing pending: %h", rsp));
            end
            else
            begin
                owed = due_rsp_q.pop_front();
                if (rsp.read_data !== owed.read_data)
                begin
                    note_failure($sformatf("read_data %h, want %h", rsp.read_data, owed.read_data));
                end
                if (rsp.red !== owed.red)
                begin
                    note_failure($sformatf("red %h, want %h", rsp.red, owed.red));
                end
                if (rsp.green !== owed.green)
                begin
                    note_failure($sformatf("green %h, want %h", rsp.green, owed.green));
                end
                if (rsp.blue !== owed.blue)
                begin
                    note_failure($sformatf("blue %h, want %h", rsp.blue, owed.blue));
                end
            end
        end
        if (!rst_n || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
    end

    initial
    begin
        do @(posedge clk); while (stall_cycles < STALL_LIMIT);
        $display("tb_tile_background_pixel_fetch failed");
        $finish;
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        run_phase(1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
        run_phase(1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        run_phase(1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
        run_phase(1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        run_phase(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        while (due_rsp_q.size() != 0) @(negedge clk);
        repeat (12) @(posedge clk);
        if (due_rsp_q.size() != 0)
        begin
            note_failure($sformatf("%0d results never arrived", due_rsp_q.size()));
        end
        if (err_count == 0)
        begin
            $display("tb_tile_background_pixel_fetch passed");
        end
        else
        begin
            $display("tb_tile_background_pixel_fetch failed");
        end
        $finish;
    end

endmodule

FILE: tile_background_pixel_fetch.f
design/tbpf_pkg.sv
design/tile_background_pixel_fetch.sv
tb/sv/tb_tile_background_pixel_fetch.sv
